### sv/ppd_pkg.sv
package ppd_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int COORD_W        = 11;
	localparam int SQ_W           = 2 * COORD_W;
	localparam int DIST_W         = SQ_W + 1;

	localparam logic [COORD_W-1:0] COORD_LIMIT = 11'd2000;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_TOO_FEW = 2'd1;
	localparam status_t ST_DROPPED = 2'd2;

	typedef enum logic {
		MODE_CLOSEST  = 1'b0,
		MODE_FARTHEST = 1'b1
	} mode_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} xy_t;

	typedef struct packed {
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic [COORD_W-1:0] first_x;
		logic [COORD_W-1:0] first_y;
		logic [COORD_W-1:0] second_x;
		logic [COORD_W-1:0] second_y;
		logic [DIST_W-1:0]  dist_squared;
		status_t            status;
	} result_t;

	// probe token walking the cell chain: one row of the pair walk
	typedef struct packed {
		logic              last_row;
		logic              have;
		xy_t               probe;
		logic [DIST_W-1:0] best_d;
		xy_t               best;
	} tok_t;

	// strict compare: ties keep the earlier pair
	function automatic logic is_better(mode_t mode, logic [DIST_W-1:0] d,
			logic [DIST_W-1:0] best);
		if (mode == MODE_FARTHEST) begin
			return d > best;
		end
		return d < best;
	endfunction

endpackage

### sv/ppd_store.sv
module ppd_store #(
	parameter int DEPTH = ppd_pkg::MAX_POINTS_DEF,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  ppd_pkg::xy_t  wr_data,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output ppd_pkg::xy_t  rd_data
);

	ppd_pkg::xy_t mem [DEPTH];
	ppd_pkg::xy_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/ppd_cell.sv
module ppd_cell #(
	parameter int MAX_POINTS = ppd_pkg::MAX_POINTS_DEF,
	parameter int CELL_IDX   = 0,
	parameter int IW         = $clog2(MAX_POINTS),
	parameter int CW         = $clog2(MAX_POINTS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_en,
	input  logic [IW-1:0]       load_idx,
	input  ppd_pkg::xy_t        load_pt,
	input  ppd_pkg::mode_t      mode,
	input  logic [CW-1:0]       n_pts,
	input  logic                tin_valid,
	input  logic [IW-1:0]       tin_idx,
	input  ppd_pkg::tok_t       tin,
	output logic                tout_valid,
	output logic [IW-1:0]       tout_idx,
	output ppd_pkg::tok_t       tout
);

	ppd_pkg::xy_t                    pt_q;
	logic [ppd_pkg::COORD_W-1:0]     dx, dy;
	logic                            active;
	logic                            valid_s1, act_s1;
	logic [IW-1:0]                   idx_s1;
	ppd_pkg::tok_t                   tok_s1;
	logic [ppd_pkg::SQ_W-1:0]        sqx_s1, sqy_s1;
	logic [ppd_pkg::DIST_W-1:0]      d;
	logic                            take;
	ppd_pkg::tok_t                   tok_nx;
	logic                            valid_s2;
	logic [IW-1:0]                   idx_s2;
	ppd_pkg::tok_t                   tok_s2;

	// this cell's point
	always_ff @(posedge clk) begin
		if (load_en && load_idx == IW'(CELL_IDX)) begin
			pt_q <= load_pt;
		end
	end

	// stage 1: absolute differences and squares
	always_comb begin
		dx = (tin.probe.x > pt_q.x) ? tin.probe.x - pt_q.x : pt_q.x - tin.probe.x;
		dy = (tin.probe.y > pt_q.y) ? tin.probe.y - pt_q.y : pt_q.y - tin.probe.y;
		active = tin_valid && (CW'(CELL_IDX) > CW'(tin_idx)) && (CW'(CELL_IDX) < n_pts);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tin_valid;
		end
	end

	always_ff @(posedge clk) begin
		act_s1 <= active;
		idx_s1 <= tin_idx;
		tok_s1 <= tin;
		sqx_s1 <= ppd_pkg::SQ_W'(dx) * ppd_pkg::SQ_W'(dx);
		sqy_s1 <= ppd_pkg::SQ_W'(dy) * ppd_pkg::SQ_W'(dy);
	end

	// stage 2: sum and strict compare against the row best
	always_comb begin
		d      = ppd_pkg::DIST_W'(sqx_s1) + ppd_pkg::DIST_W'(sqy_s1);
		take   = act_s1 && (!tok_s1.have || ppd_pkg::is_better(mode, d, tok_s1.best_d));
		tok_nx = tok_s1;
		if (take) begin
			tok_nx.have   = 1'b1;
			tok_nx.best_d = d;
			tok_nx.best   = pt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		tok_s2 <= tok_nx;
	end

	assign tout_valid = valid_s2;
	assign tout_idx   = idx_s2;
	assign tout       = tok_s2;

endmodule

### sv/ppd_merge.sv
module ppd_merge (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clear,
	input  ppd_pkg::mode_t mode,
	input  logic           tin_valid,
	input  ppd_pkg::tok_t  tin,
	output logic           done,
	output ppd_pkg::tok_t  best
);

	logic          have_q;
	logic          done_q;
	ppd_pkg::tok_t best_q;
	logic          upd;

	// rows arrive in probe order; strict compare keeps the earliest row on ties
	assign upd = tin_valid && tin.have &&
		(!have_q || ppd_pkg::is_better(mode, tin.best_d, best_q.best_d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= tin_valid && tin.last_row;
			if (clear) begin
				have_q <= 1'b0;
			end else if (upd) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && upd) begin
			best_q <= tin;
		end
	end

	assign done = done_q;
	assign best = best_q;

endmodule

### sv/point_pair_distance_search.sv
// Brute-force closest / farthest pair search over a set of 2-D points.
// Points load one per cycle (a coordinate above 2000 stores as (0,0)); points past
// MAX_POINTS are dropped and the result is flagged. The transfer marked last_point
// starts the search: every point i but the last is read from the point memory in
// turn, one per cycle, and sent as a probe down a chain of MAX_POINTS cells, each
// holding one stored point and comparing it with the probe over two register
// stages. The row winners are merged at the end of the chain. The result is
// presented once the last probe has left the cell chain and the merge is done; a
// set of fewer than two points skips the search and answers from the finish state.
// No point is taken while a search runs or while its result waits behind an
// earlier stalled result. mode_data selects closest (0) or farthest (1); the user
// must write it through the mode channel only while the block is idle; the block
// itself does not enforce this.
module point_pair_distance_search #(
	parameter int MAX_POINTS = ppd_pkg::MAX_POINTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             point_valid,
	output logic             point_stall,
	input  ppd_pkg::point_t  point,
	output logic             result_valid,
	input  logic             result_stall,
	output ppd_pkg::result_t result,
	input  logic             mode_valid,
	output logic             mode_ready,
	input  logic             mode_data
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [1:0] {
		S_LOAD,
		S_SEARCH,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    cnt_q;
	logic             ovf_q, tf_q;
	logic [IW-1:0]    rd_idx_q;
	logic             res_valid_q;
	ppd_pkg::result_t result_q;
	ppd_pkg::mode_t   mode_q;

	logic             acc, store_ok, oob, rd_en, rd_last, fin_go;
	logic [CW-1:0]    cnt_nx;
	ppd_pkg::xy_t     ld_pt, rd_data;
	logic             rd_valid_s1, rd_last_s1;
	logic [IW-1:0]    rd_idx_s1;
	logic             merge_done;
	ppd_pkg::tok_t    merge_best;

	logic             cv [MAX_POINTS+1];
	logic [IW-1:0]    ci [MAX_POINTS+1];
	ppd_pkg::tok_t    ct [MAX_POINTS+1];

	// mode register
	assign mode_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ppd_pkg::MODE_CLOSEST;
		end else if (mode_valid) begin
			mode_q <= ppd_pkg::mode_t'(mode_data);
		end
	end

	// input transfer and point clamp
	always_comb begin
		point_stall = (state_q != S_LOAD);
		acc         = point_valid && !point_stall;
		store_ok    = cnt_q < CW'(MAX_POINTS);
		cnt_nx      = cnt_q + CW'(store_ok);
		oob         = (point.coord_x > ppd_pkg::COORD_LIMIT) ||
			(point.coord_y > ppd_pkg::COORD_LIMIT);
		ld_pt.x     = oob ? '0 : point.coord_x;
		ld_pt.y     = oob ? '0 : point.coord_y;
		rd_en       = (state_q == S_SEARCH);
		rd_last     = CW'(rd_idx_q) == cnt_q - CW'(2);
		fin_go      = (state_q == S_FINISH) && (!res_valid_q || !result_stall);
	end

	ppd_store #(
		.DEPTH (MAX_POINTS),
		.IW    (IW)
	) u_store (
		.clk     (clk),
		.wr_en   (acc && store_ok),
		.wr_addr (cnt_q[IW-1:0]),
		.wr_data (ld_pt),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// probe issue stage, lined up with the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1  <= rd_idx_q;
		rd_last_s1 <= rd_last;
	end

	assign cv[0]          = rd_valid_s1;
	assign ci[0]          = rd_idx_s1;
	assign ct[0].last_row = rd_last_s1;
	assign ct[0].have     = 1'b0;
	assign ct[0].probe    = rd_data;
	assign ct[0].best_d   = '0;
	assign ct[0].best     = '0;

	// cell chain
	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
		ppd_cell #(
			.MAX_POINTS (MAX_POINTS),
			.CELL_IDX   (g),
			.IW         (IW),
			.CW         (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.load_en    (acc && store_ok),
			.load_idx   (cnt_q[IW-1:0]),
			.load_pt    (ld_pt),
			.mode       (mode_q),
			.n_pts      (cnt_q),
			.tin_valid  (cv[g]),
			.tin_idx    (ci[g]),
			.tin        (ct[g]),
			.tout_valid (cv[g+1]),
			.tout_idx   (ci[g+1]),
			.tout       (ct[g+1])
		);
	end

	ppd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (acc && point.last_point),
		.mode      (mode_q),
		.tin_valid (cv[MAX_POINTS]),
		.tin       (ct[MAX_POINTS]),
		.done      (merge_done),
		.best      (merge_best)
	);

	// sequencer: load, issue probes, wait for the chain, deliver the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			tf_q        <= 1'b0;
			rd_idx_q    <= '0;
			res_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (acc) begin
						if (store_ok) begin
							cnt_q <= cnt_nx;
						end else begin
							ovf_q <= 1'b1;
						end
						if (point.last_point) begin
							rd_idx_q <= '0;
							if (cnt_nx < CW'(2)) begin
								tf_q    <= 1'b1;
								state_q <= S_FINISH;
							end else begin
								state_q <= S_SEARCH;
							end
						end
					end
				end
				S_SEARCH: begin
					if (rd_last) begin
						state_q <= S_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + IW'(1);
					end
				end
				S_DRAIN: begin
					if (merge_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						if (tf_q) begin
							result_q.first_x      <= '0;
							result_q.first_y      <= '0;
							result_q.second_x     <= '0;
							result_q.second_y     <= '0;
							result_q.dist_squared <= '0;
							result_q.status       <= ppd_pkg::ST_TOO_FEW;
						end else begin
							result_q.first_x      <= merge_best.probe.x;
							result_q.first_y      <= merge_best.probe.y;
							result_q.second_x     <= merge_best.best.x;
							result_q.second_y     <= merge_best.best.y;
							result_q.dist_squared <= merge_best.best_d;
							result_q.status       <= ovf_q ? ppd_pkg::ST_DROPPED
								: ppd_pkg::ST_OK;
						end
						cnt_q       <= '0;
						ovf_q       <= 1'b0;
						tf_q        <= 1'b0;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

endmodule
